// ===== rtl/core/bbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, codes and character classification shared by the bracket checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // Kind of bracket held in one stack cell.
  typedef enum logic [1:0] {
    KIND_PAREN   = 2'd0,
    KIND_BRACE   = 2'd1,
    KIND_BRACKET = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // Failure cause reported with each verdict.
  typedef enum logic [2:0] {
    CAUSE_OK       = 3'd0,
    CAUSE_NO_OPEN  = 3'd1,
    CAUSE_MISMATCH = 3'd2,
    CAUSE_UNCLOSED = 3'd3,
    CAUSE_OVERFLOW = 3'd4
  } cause_t;

  localparam logic [7:0] CHAR_LPAREN   = 8'h28;
  localparam logic [7:0] CHAR_RPAREN   = 8'h29;
  localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;

  // Shift command broadcast to every cell of the stack chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  // One verdict as it travels to the output stage.
  typedef struct packed {
    logic   balanced;
    cause_t fail_cause;
  } result_t;

  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CHAR_LPAREN:   k = KIND_PAREN;
      CHAR_LBRACE:   k = KIND_BRACE;
      CHAR_LBRACKET: k = KIND_BRACKET;
      default:       k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CHAR_RPAREN:   k = KIND_PAREN;
      CHAR_RBRACE:   k = KIND_BRACE;
      CHAR_RBRACKET: k = KIND_BRACKET;
      default:       k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/bbc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_in_if / bbc_out_if
// Valid/ready channels for character requests and verdict requests.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_expr;

  modport source (output valid, output char_in, output end_of_expr, input ready);
  modport sink (input valid, input char_in, input end_of_expr, output ready);
endinterface

interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [2:0] fail_cause;

  modport source (output valid, output balanced, output fail_cause, input ready);
  modport sink (input valid, input balanced, input fail_cause, output ready);
endinterface

// ===== rtl/core/bracket_balance_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_unit
// Balanced-bracket checker over a byte stream, one verdict per expression.
// ----------------------------------------------------------------------------
// The unit takes one character request per clock cycle, with no gaps needed
// between expressions, and returns one verdict request for each character
// marked end_of_expr that is taken. The bracket stack is a chain of
// STACK_DEPTH two-bit cells that all shift together, so a push or a pop
// moves every cell at once and a pop compares against the top cell. The
// verdict sits in an output register backed by a one-entry skid buffer; the
// input only stalls when both hold verdicts the consumer has not taken.
// Openers beyond STACK_DEPTH report overflow (cause 4) instead of being
// dropped. The first failure of an expression is kept; depth and failure
// clear after the last character so the next expression starts fresh.
module bracket_balance_checker_unit #(
  parameter int STACK_DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    chars,
  bbc_out_if.source verdict
);
  import bbc_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);

  // Occupancy of the stack chain and the first failure of this expression.
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_next;
  cause_t        sticky;
  cause_t        sticky_next;

  logic    room;
  logic    accept;
  logic    last;
  kind_t   okind;
  kind_t   ckind;
  shift_t  cmd;
  kind_t   cell_kind [STACK_DEPTH];
  result_t result;
  cause_t  cause;

  assign chars.ready = room;
  assign accept      = chars.valid && room;
  assign last        = accept && chars.end_of_expr;
  assign okind       = open_kind(chars.char_in);
  assign ckind       = close_kind(chars.char_in);

  // Stack control. Once a failure is recorded, later characters of the same
  // expression leave the stack alone.
  always_comb begin
    cmd         = '0;
    depth_next  = depth;
    sticky_next = sticky;
    if (accept && sticky == CAUSE_OK) begin
      if (okind != KIND_NONE) begin
        if (depth == DW'(STACK_DEPTH)) begin
          sticky_next = CAUSE_OVERFLOW;
        end else begin
          cmd.push   = 1'b1;
          depth_next = depth + 1'b1;
        end
      end else if (ckind != KIND_NONE) begin
        if (depth == '0) begin
          sticky_next = CAUSE_NO_OPEN;
        end else begin
          cmd.pop    = 1'b1;
          depth_next = depth - 1'b1;
          if (cell_kind[0] != ckind) begin
            sticky_next = CAUSE_MISMATCH;
          end
        end
      end
    end

    // Verdict for the expression that ends with this character.
    cause = sticky_next;
    if (cause == CAUSE_OK && depth_next != '0) begin
      cause = CAUSE_UNCLOSED;
    end
    result.balanced   = (cause == CAUSE_OK);
    result.fail_cause = cause;
  end

  always_ff @(posedge clk) begin
    if (rst || last) begin
      depth  <= '0;
      sticky <= CAUSE_OK;
    end else begin
      depth  <= depth_next;
      sticky <= sticky_next;
    end
  end

  // The stack chain: cell 0 is the top. A push feeds the new kind into the
  // top; a pop feeds each cell from the one below it.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_t above;
    kind_t below;
    if (i == 0) begin : g_top
      assign above = okind;
    end else begin : g_mid
      assign above = cell_kind[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = KIND_NONE;
    end else begin : g_rest
      assign below = cell_kind[i+1];
    end
    bbc_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .from_above (above),
      .from_below (below),
      .kind       (cell_kind[i])
    );
  end

  bbc_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (last),
    .result  (result),
    .room    (room),
    .verdict (verdict)
  );

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    last |=> (depth == '0 && sticky == CAUSE_OK))
    else $error("state not cleared after end of expression");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    (sticky != CAUSE_OK && !last) |=> (sticky == $past(sticky) && depth == $past(depth)))
    else $error("recorded failure or depth changed before end of expression");

  a_no_push_and_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop issued together");
`endif

endmodule

// ===== rtl/core/bbc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_cell
// One entry of the shifting bracket stack.
// ----------------------------------------------------------------------------
module bbc_cell (
  input  logic           clk,
  input  bbc_pkg::shift_t cmd,
  input  bbc_pkg::kind_t  from_above,
  input  bbc_pkg::kind_t  from_below,
  output bbc_pkg::kind_t  kind
);
  import bbc_pkg::*;

  // A push moves every entry one place deeper; a pop moves it one place up.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      kind <= from_above;
    end else if (cmd.pop) begin
      kind <= from_below;
    end
  end

endmodule

// ===== rtl/core/bbc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_out_stage
// Output register with a one-entry skid buffer for verdict requests.
// ----------------------------------------------------------------------------
module bbc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bbc_pkg::result_t  result,
  output logic              room,
  bbc_out_if.source         verdict
);
  import bbc_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    drain;

  assign drain = verdict.ready || !out_valid;
  assign room  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (load) begin
      skid_data <= result;
    end
  end

  assign verdict.valid      = out_valid;
  assign verdict.balanced   = out_data.balanced;
  assign verdict.fail_cause = out_data.fail_cause;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bracket balance checker. A short table of
// directed character requests covers the named corner cases, then random
// expressions (well formed, broken, noise, and full-depth stacks) run under
// four back-pressure phases. Every verdict request is compared field by field
// with the table's verdict or with a bench-side model of the bracket stack.
// ----------------------------------------------------------------------------
module tb_top;
  import bbc_pkg::*;

  localparam int STACK_CELLS    = 128;
  localparam int PHASE_ITEMS    = 40;    // random character requests per phase
  localparam int SETTLE_CYCLES  = 4;     // idle time after the last verdict is back
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int NEST_LIMIT     = 12;    // nesting bound for random expressions

  localparam logic [7:0] OPENERS [3] = '{CHAR_LPAREN, CHAR_LBRACE, CHAR_LBRACKET};
  localparam logic [7:0] CLOSERS [3] = '{CHAR_RPAREN, CHAR_RBRACE, CHAR_RBRACKET};
  localparam logic [7:0] BRACKET_CHARS [6] = '{CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACE,
                                               CHAR_RBRACE, CHAR_LBRACKET, CHAR_RBRACKET};

  // One row of the directed table. Rows with has_verdict set carry a verdict
  // that is obvious by inspection; all other rows fall back on the model.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       has_verdict;
    logic       balanced;
    cause_t     cause;
  } char_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam char_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    // A lone closer right after reset.
    '{CHAR_RPAREN,   1'b1, 1'b1, 1'b0, CAUSE_NO_OPEN},
    // Simplest balanced pair.
    '{CHAR_LPAREN,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RPAREN,   1'b1, 1'b1, 1'b1, CAUSE_OK},
    // Nested braces and brackets with the lowest filler byte in between.
    '{CHAR_LBRACE,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_LBRACKET, 1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{8'h00,         1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RBRACKET, 1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RBRACE,   1'b1, 1'b0, 1'b0, CAUSE_OK},
    // Mismatched pair.
    '{CHAR_LPAREN,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RBRACKET, 1'b1, 1'b1, 1'b0, CAUSE_MISMATCH},
    // An opener that is also the last byte stays unclosed.
    '{CHAR_LBRACKET, 1'b1, 1'b1, 1'b0, CAUSE_UNCLOSED},
    // The first failure sticks even though the rest would balance.
    '{CHAR_RBRACE,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_LPAREN,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RPAREN,   1'b1, 1'b1, 1'b0, CAUSE_NO_OPEN},
    // Highest byte alone, no brackets at all.
    '{8'hFF,         1'b1, 1'b1, 1'b1, CAUSE_OK},
    // Mismatch followed by a closer on an empty stack: mismatch is kept.
    '{CHAR_LBRACE,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RPAREN,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RBRACE,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_LBRACKET, 1'b1, 1'b1, 1'b0, CAUSE_MISMATCH},
    // Plain text.
    '{8'h41,         1'b1, 1'b1, 1'b1, CAUSE_OK},
    // One pair closed, one left open, ended by a space.
    '{CHAR_LBRACE,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_LPAREN,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{CHAR_RPAREN,   1'b0, 1'b0, 1'b0, CAUSE_OK},
    '{8'h20,         1'b1, 1'b0, 1'b0, CAUSE_OK}
  };

  logic clk;
  logic rst;

  bbc_in_if  chars_if ();
  bbc_out_if verdict_if ();

  bracket_balance_checker_unit #(
    .STACK_DEPTH(STACK_CELLS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .verdict(verdict_if)
  );

  // Bench-side copy of the checker state.
  kind_t       model_stack [STACK_CELLS];
  int unsigned model_depth;
  cause_t      model_fail;

  result_t     pending_verdicts [$];
  int          error_count;
  int          phase_items;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the bracket state by one accepted character. On the last byte
  // of an expression it returns the verdict and clears the state. Once a
  // failure is recorded the rest of the expression leaves the stack alone.
  function automatic bit track_bracket(input logic [7:0] ch, input logic last,
                                       output result_t verdict);
    kind_t  opened;
    kind_t  closed;
    cause_t cause;
    opened = KIND_NONE;
    closed = KIND_NONE;
    case (ch)
      CHAR_LPAREN:   opened = KIND_PAREN;
      CHAR_LBRACE:   opened = KIND_BRACE;
      CHAR_LBRACKET: opened = KIND_BRACKET;
      CHAR_RPAREN:   closed = KIND_PAREN;
      CHAR_RBRACE:   closed = KIND_BRACE;
      CHAR_RBRACKET: closed = KIND_BRACKET;
      default: ;
    endcase
    if (model_fail == CAUSE_OK) begin
      if (opened != KIND_NONE) begin
        if (model_depth >= STACK_CELLS) begin
          model_fail = CAUSE_OVERFLOW;
        end else begin
          model_stack[model_depth] = opened;
          model_depth++;
        end
      end else if (closed != KIND_NONE) begin
        if (model_depth == 0) begin
          model_fail = CAUSE_NO_OPEN;
        end else begin
          model_depth--;
          if (model_stack[model_depth] != closed) model_fail = CAUSE_MISMATCH;
        end
      end
    end
    verdict = '0;
    if (!last) return 1'b0;
    cause = model_fail;
    if (cause == CAUSE_OK && model_depth != 0) cause = CAUSE_UNCLOSED;
    verdict.balanced   = (cause == CAUSE_OK);
    verdict.fail_cause = cause;
    model_depth = 0;
    model_fail  = CAUSE_OK;
    return 1'b1;
  endfunction

  // Drives one character request. Called and returns at a falling edge, so
  // valid is assigned at most once per time step. When use_row is set the
  // verdict typed into the table replaces the modeled one.
  task automatic send_char(input logic [7:0] ch, input logic last,
                           input bit use_row = 1'b0, input result_t row_verdict = '0);
    result_t verdict;
    while ($urandom_range(99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid       <= 1'b1;
    chars_if.char_in     <= ch;
    chars_if.end_of_expr <= last;
    do @(posedge clk); while (!chars_if.ready);
    if (track_bracket(ch, last, verdict)) begin
      pending_verdicts.push_back(use_row ? row_verdict : verdict);
    end
    phase_items++;
    @(negedge clk);
  endtask

  // Sends a queued expression. The last byte always closes it; noisy
  // expressions also end at random points along the way.
  task automatic send_expression(input logic [7:0] bytes [$], input bit noisy);
    for (int i = 0; i < bytes.size(); i++) begin
      send_char(bytes[i], (i == bytes.size() - 1) || (noisy && $urandom_range(5) == 0));
    end
  endtask

  // Random properly nested expression with filler bytes between brackets.
  task automatic build_nested(ref logic [7:0] bytes [$]);
    int          open_kinds [$];
    int          steps;
    int          choice;
    int          k;
    logic [7:0]  filler;
    bytes.delete();
    steps = $urandom_range(20, 1);
    for (int i = 0; i < steps; i++) begin
      choice = $urandom_range(2);
      if (choice == 1 && open_kinds.size() < NEST_LIMIT) begin
        k = $urandom_range(2);
        open_kinds.push_back(k);
        bytes.push_back(OPENERS[k]);
      end else if (choice == 2 && open_kinds.size() > 0) begin
        bytes.push_back(CLOSERS[open_kinds.pop_back()]);
      end else begin
        do filler = 8'($urandom_range(255));
        while (filler inside {CHAR_LPAREN, CHAR_RPAREN, CHAR_LBRACE,
                              CHAR_RBRACE, CHAR_LBRACKET, CHAR_RBRACKET});
        bytes.push_back(filler);
      end
    end
    while (open_kinds.size() > 0) bytes.push_back(CLOSERS[open_kinds.pop_back()]);
  endtask

  // A run of openers of random kinds followed by the matching closers. At
  // STACK_CELLS openers the stack is exactly full; one more overflows it.
  task automatic build_deep(ref logic [7:0] bytes [$], input int opens);
    int open_kinds [$];
    int k;
    bytes.delete();
    for (int i = 0; i < opens; i++) begin
      k = $urandom_range(2);
      open_kinds.push_back(k);
      bytes.push_back(OPENERS[k]);
    end
    while (open_kinds.size() > 0) bytes.push_back(CLOSERS[open_kinds.pop_back()]);
  endtask

  // Holds the sender off until every verdict is back, then lets the unit
  // settle before the next step.
  task automatic drain_verdicts();
    chars_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The receiver stalls at random; the phase sets how often.
  always @(negedge clk) begin
    verdict_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Each verdict request taken is checked against the oldest expectation.
  always @(posedge clk) begin
    result_t exp_verdict;
    if (!rst && verdict_if.valid && verdict_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict with no expectation: balanced=%0b fail_cause=%0d",
               verdict_if.balanced, verdict_if.fail_cause);
        error_count++;
      end else begin
        exp_verdict = pending_verdicts.pop_front();
        if (verdict_if.balanced !== exp_verdict.balanced) begin
          $error("balanced: expected %0b, actual %0b",
                 exp_verdict.balanced, verdict_if.balanced);
          error_count++;
        end
        if (verdict_if.fail_cause !== exp_verdict.fail_cause) begin
          $error("fail_cause: expected %0d, actual %0d",
                 exp_verdict.fail_cause, verdict_if.fail_cause);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) ||
        (verdict_if.valid && verdict_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] expr_bytes [$];
    char_row_t  row;
    result_t    row_verdict;
    int         pos;
    int         mode;

    chars_if.valid       = 1'b0;
    chars_if.char_in     = 8'h00;
    chars_if.end_of_expr = 1'b0;
    rst                  = 1'b1;
    error_count          = 0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    model_depth          = 0;
    model_fail           = CAUSE_OK;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, walked with no idling on either side.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row                    = DIRECTED_TABLE[i];
      row_verdict.balanced   = row.balanced;
      row_verdict.fail_cause = row.cause;
      send_char(row.ch, row.last, row.has_verdict, row_verdict);
    end
    drain_verdicts();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 79 : (phase == 3) ? 33 : 0;
      recv_stall_pct = (phase == 2) ? 79 : (phase == 3) ? 33 : 0;
      phase_items    = 0;

      // Full stack in the first phase, overflow in the last.
      if (phase == 0) begin
        build_deep(expr_bytes, STACK_CELLS);
        send_expression(expr_bytes, 1'b0);
      end else if (phase == 3) begin
        build_deep(expr_bytes, STACK_CELLS + 1);
        send_expression(expr_bytes, 1'b0);
      end
      phase_items = 0;

      while (phase_items < PHASE_ITEMS) begin
        mode = $urandom_range(99);
        if (mode < 60) begin
          build_nested(expr_bytes);
          send_expression(expr_bytes, 1'b0);
        end else if (mode < 85) begin
          // Break a well-formed expression at one spot: swap in a random
          // bracket, drop a byte, or slip in an extra closer.
          build_nested(expr_bytes);
          pos = $urandom_range(expr_bytes.size() - 1);
          case ($urandom_range(2))
            0: expr_bytes[pos] = BRACKET_CHARS[$urandom_range(5)];
            1: if (expr_bytes.size() > 1) expr_bytes.delete(pos);
            default: expr_bytes.insert(pos, CLOSERS[$urandom_range(2)]);
          endcase
          send_expression(expr_bytes, 1'b0);
        end else begin
          expr_bytes.delete();
          repeat ($urandom_range(12, 1)) begin
            if ($urandom_range(1)) expr_bytes.push_back(BRACKET_CHARS[$urandom_range(5)]);
            else expr_bytes.push_back(8'($urandom_range(255)));
          end
          send_expression(expr_bytes, 1'b1);
        end
      end
      drain_verdicts();
    end

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
